/* rtl/stopword_binary_search_filter_assert.svh */
// Assertion macros shared by the stop-word filter RTL.
// Needs a clk and an arst_n in the scope of the use.
`ifndef STOPWORD_BINARY_SEARCH_FILTER_ASSERT_SVH
`define STOPWORD_BINARY_SEARCH_FILTER_ASSERT_SVH

// Implication checked at every edge, off while reset is held.
`define SWBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Non-overlapping implication, off while reset is held.
`define SWBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/swbs_pkg.sv */
// Shared types and constants of the stop-word filter.
// No dependencies.
`default_nettype none
package swbs_pkg;
	localparam int WORD_BYTES_DEF    = 32;
	localparam int TABLE_ENTRIES_DEF = 256;
	// widest length and count over the parameter ranges
	localparam int LEN_W = 6;
	localparam int CNT_W = 13;

	typedef enum logic [1:0] {
		KIND_TOKEN = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef struct packed {
		logic             is_word;
		logic             too_long;
		logic [LEN_W-1:0] word_len;
		logic [CNT_W-1:0] count;
	} req_t;

	typedef struct packed {
		logic busy;
	} back_status_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7a) begin
			r = c - 8'h20;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/swbs_if.sv */
// Channel interfaces of the stop-word filter: input items and results.
// No dependencies.
`default_nettype none
interface swbs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_code;
	logic       char_valid;
	logic       last;
	logic       is_word;
	modport source (output valid, kind, char_code, char_valid, last, is_word, input ready);
	modport sink (input valid, kind, char_code, char_valid, last, is_word, output ready);
endinterface

interface swbs_out_if;
	logic valid;
	logic ready;
	logic is_noise;
	logic too_long;
	modport source (output valid, is_noise, too_long, input ready);
	modport sink (input valid, is_noise, too_long, output ready);
endinterface
`default_nettype wire

/* rtl/swbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module swbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/swbs_front.sv */
// Front end: accepts items, loads the table, fills the word buffer and
// queues a search request at each token end. Uses swbs_pkg and swbs_if.
`default_nettype none
module swbs_front #(
	parameter int WB = swbs_pkg::WORD_BYTES_DEF,
	parameter int TE = swbs_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	swbs_in_if.sink                        in_ch,
	input  wire logic                      hold,
	output logic                           push,
	output swbs_pkg::req_t                 req,
	output logic                           tbl_we,
	output logic [$clog2(TE*WB)-1:0]       tbl_waddr,
	output logic [7:0]                     tbl_wdata,
	output logic                           len_we,
	output logic [(TE > 1 ? $clog2(TE) : 1)-1:0] len_waddr,
	output logic [$clog2(WB+1)-1:0]        len_wdata,
	output logic                           wbuf_we,
	output logic [$clog2(WB)-1:0]          wbuf_waddr,
	output logic [7:0]                     wbuf_wdata
);
	localparam int LW  = $clog2(WB + 1);
	localparam int CW  = $clog2(TE + 1);
	localparam int IW  = (TE > 1) ? $clog2(TE) : 1;
	localparam int TAW = $clog2(TE * WB);
	localparam int BW  = $clog2(WB);

	logic [CW-1:0]  count_q;
	logic [LW-1:0]  lpos_q;
	logic [LW-1:0]  wlen_q;
	logic [LW-1:0]  wlen_next;
	logic [TAW:0]   tbl_lin;
	logic           accept;
	logic           ent;
	logic           tok;
	logic           clr;

	assign in_ch.ready = !hold;
	assign accept = in_ch.valid && in_ch.ready;
	assign ent = accept && (in_ch.kind == swbs_pkg::KIND_ENTRY) && (count_q < CW'(TE));
	assign clr = accept && (in_ch.kind == swbs_pkg::KIND_CLEAR);
	assign tok = accept && (in_ch.kind == swbs_pkg::KIND_TOKEN);

	assign tbl_lin   = (TAW+1)'(count_q) * (TAW+1)'(WB) + (TAW+1)'(lpos_q);
	assign tbl_we    = ent && in_ch.char_valid && (lpos_q < LW'(WB));
	assign tbl_waddr = tbl_lin[TAW-1:0];
	assign tbl_wdata = in_ch.char_code;

	assign len_we    = ent && in_ch.last;
	assign len_waddr = IW'(count_q);
	assign len_wdata = lpos_q + LW'(tbl_we);

	assign wbuf_we    = tok && in_ch.char_valid && (wlen_q < LW'(WB));
	assign wbuf_waddr = wlen_q[BW-1:0];
	assign wbuf_wdata = swbs_pkg::to_upper(in_ch.char_code);
	assign wlen_next  = wlen_q + LW'(wbuf_we);

	assign push = tok && in_ch.last;
	always_comb begin
		req.is_word  = in_ch.is_word;
		req.too_long = (wlen_next >= LW'(WB));
		req.word_len = swbs_pkg::LEN_W'(wlen_next);
		req.count    = swbs_pkg::CNT_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lpos_q  <= '0;
			wlen_q  <= '0;
		end else begin
			if (clr) begin
				count_q <= '0;
				lpos_q  <= '0;
			end else if (len_we) begin
				count_q <= count_q + 1'b1;
				lpos_q  <= '0;
			end else if (tbl_we) begin
				lpos_q <= lpos_q + 1'b1;
			end
			if (push) begin
				wlen_q <= '0;
			end else if (tok) begin
				wlen_q <= wlen_next;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/swbs_queue.sv */
// Two-entry request queue between the front end and the search engine.
// Uses swbs_pkg.
`default_nettype none
module swbs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  swbs_pkg::req_t      push_req,
	input  wire logic           pop,
	output swbs_pkg::req_t      head,
	output logic                empty,
	output logic                full
);
	swbs_pkg::req_t slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= !wr_q;
			end
			if (pop && !empty) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

/* rtl/swbs_back.sv */
// Search engine: binary search over the stored table, one byte compare per
// S_RD/S_CMP pass, result held in an output register. Uses swbs_pkg, swbs_if.
`default_nettype none
module swbs_back #(
	parameter int WB = swbs_pkg::WORD_BYTES_DEF,
	parameter int TE = swbs_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  swbs_pkg::req_t                 req,
	input  wire logic                      req_valid,
	output logic                           pop,
	output logic [$clog2(TE*WB)-1:0]       tbl_raddr,
	input  wire logic [7:0]                tbl_rdata,
	output logic [(TE > 1 ? $clog2(TE) : 1)-1:0] len_raddr,
	input  wire logic [$clog2(WB+1)-1:0]   len_rdata,
	output logic [$clog2(WB)-1:0]          wbuf_raddr,
	input  wire logic [7:0]                wbuf_rdata,
	swbs_out_if.source                     out_ch,
	output swbs_pkg::back_status_t         status
);
	localparam int LW  = $clog2(WB + 1);
	localparam int CW  = $clog2(TE + 1);
	localparam int IW  = (TE > 1) ? $clog2(TE) : 1;
	localparam int TAW = $clog2(TE * WB);
	localparam int BW  = $clog2(WB);

	typedef enum logic [2:0] {
		S_IDLE, S_MID, S_LEN, S_LENW, S_RD, S_CMP, S_DONE
	} state_t;

	state_t        state_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [IW-1:0] mid_q;
	logic [TAW-1:0] base_q;
	logic [LW-1:0] elen_q;
	logic [LW-1:0] wlen_q;
	logic [LW-1:0] p_q;
	logic          noise_q;
	logic          long_q;
	logic          out_valid_q;
	logic          out_noise_q;
	logic          out_long_q;
	logic [CW:0]   mid_sum;
	logic [7:0]    a_byte;
	logic [7:0]    b_byte;

	assign pop        = (state_q == S_IDLE) && req_valid;
	assign len_raddr  = mid_q;
	assign tbl_raddr  = base_q + TAW'(p_q);
	assign wbuf_raddr = p_q[BW-1:0];
	assign mid_sum    = ((CW+1)'(lo_q) + (CW+1)'(hi_q) - 1'b1) >> 1;
	assign a_byte     = (p_q < elen_q) ? tbl_rdata : 8'h00;
	assign b_byte     = (p_q < wlen_q) ? wbuf_rdata : 8'h00;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.is_noise = out_noise_q;
	assign out_ch.too_long = out_long_q;
	assign status.busy     = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						wlen_q <= LW'(req.word_len);
						lo_q   <= '0;
						hi_q   <= CW'(req.count);
						if (req.is_word && !req.too_long) begin
							state_q <= S_MID;
						end else begin
							noise_q <= 1'b0;
							long_q  <= req.is_word && req.too_long;
							state_q <= S_DONE;
						end
					end
				end
				S_MID: begin
					if (lo_q < hi_q) begin
						mid_q   <= IW'(mid_sum);
						state_q <= S_LEN;
					end else begin
						noise_q <= 1'b0;
						long_q  <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_LEN: begin
					base_q  <= TAW'((TAW+1)'(mid_q) * (TAW+1)'(WB));
					state_q <= S_LENW;
				end
				S_LENW: begin
					elen_q  <= len_rdata;
					p_q     <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (a_byte != b_byte) begin
						// narrow the range toward the word
						if (a_byte < b_byte) begin
							lo_q <= CW'(mid_q) + 1'b1;
						end else begin
							hi_q <= CW'(mid_q);
						end
						state_q <= S_MID;
					end else if (a_byte == 8'h00) begin
						// an overlong entry sorts above an equal word
						if (elen_q >= LW'(WB)) begin
							hi_q    <= CW'(mid_q);
							state_q <= S_MID;
						end else begin
							noise_q <= 1'b1;
							long_q  <= 1'b0;
							state_q <= S_DONE;
						end
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_noise_q <= noise_q;
						out_long_q  <= long_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/stopword_binary_search_filter.sv */
// A token end yields one result; a word shorter than the buffer is looked up by a binary
// search of up to ceil(log2(entries+1)) probes, each comparing bytes until they differ
// or both end. Other items give no result.
// Throughput: one item per cycle while no search is pending; input stalls during a search.
// The byte compare loop over the table RAM sets the search time.
// Reset: asynchronous, active low; clears the table count, load position and token length.
`default_nettype none
`include "stopword_binary_search_filter_assert.svh"
module stopword_binary_search_filter #(
	parameter int WORD_BYTES    = swbs_pkg::WORD_BYTES_DEF,
	parameter int TABLE_ENTRIES = swbs_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	swbs_in_if.sink    in_ch,
	swbs_out_if.source out_ch
);
	localparam int LW  = $clog2(WORD_BYTES + 1);
	localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TAW = $clog2(TABLE_ENTRIES * WORD_BYTES);
	localparam int BW  = $clog2(WORD_BYTES);

	logic                   push;
	logic                   pop;
	logic                   q_empty;
	logic                   q_full;
	logic                   hold;
	swbs_pkg::req_t         push_req;
	swbs_pkg::req_t         head_req;
	swbs_pkg::back_status_t back_st;
	logic                   tbl_we;
	logic [TAW-1:0]         tbl_waddr;
	logic [7:0]             tbl_wdata;
	logic [TAW-1:0]         tbl_raddr;
	logic [7:0]             tbl_rdata;
	logic                   len_we;
	logic [IW-1:0]          len_waddr;
	logic [LW-1:0]          len_wdata;
	logic [IW-1:0]          len_raddr;
	logic [LW-1:0]          len_rdata;
	logic                   wbuf_we;
	logic [BW-1:0]          wbuf_waddr;
	logic [7:0]             wbuf_wdata;
	logic [BW-1:0]          wbuf_raddr;
	logic [7:0]             wbuf_rdata;

	// hold input while a search owns the word buffer
	assign hold = !q_empty || back_st.busy;

	swbs_front #(.WB(WORD_BYTES), .TE(TABLE_ENTRIES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .hold(hold),
		.push(push), .req(push_req),
		.tbl_we(tbl_we), .tbl_waddr(tbl_waddr), .tbl_wdata(tbl_wdata),
		.len_we(len_we), .len_waddr(len_waddr), .len_wdata(len_wdata),
		.wbuf_we(wbuf_we), .wbuf_waddr(wbuf_waddr), .wbuf_wdata(wbuf_wdata)
	);

	swbs_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_req(push_req),
		.pop(pop), .head(head_req), .empty(q_empty), .full(q_full)
	);

	swbs_back #(.WB(WORD_BYTES), .TE(TABLE_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .req(head_req), .req_valid(!q_empty), .pop(pop),
		.tbl_raddr(tbl_raddr), .tbl_rdata(tbl_rdata),
		.len_raddr(len_raddr), .len_rdata(len_rdata),
		.wbuf_raddr(wbuf_raddr), .wbuf_rdata(wbuf_rdata),
		.out_ch(out_ch), .status(back_st)
	);

	swbs_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * WORD_BYTES)) u_tbl_ram (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	swbs_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.raddr(len_raddr), .rdata(len_rdata)
	);

	swbs_ram #(.WIDTH(8), .DEPTH(WORD_BYTES)) u_wbuf_ram (
		.clk(clk), .we(wbuf_we), .waddr(wbuf_waddr), .wdata(wbuf_wdata),
		.raddr(wbuf_raddr), .rdata(wbuf_rdata)
	);

	`SWBS_ASSERT_IMP(a_accept_idle, in_ch.valid && in_ch.ready, q_empty && !back_st.busy, "item accepted during a search")
	`SWBS_ASSERT_IMP(a_push_room, push, !q_full, "request pushed into a full queue")
	`SWBS_ASSERT_NEXT(a_pop_busy, pop, back_st.busy, "search engine idle after taking a request")
endmodule
`default_nettype wire
